// ===== sv/dipv4_pkg.sv =====
// dipv4_pkg: shared constants for the dotted-quad text to integer converter
// character codes, field widths and the part limit; depends on nothing

package dipv4_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned PART_W  = 8;
    localparam int unsigned DOTS_W  = 2;
    // wide enough for part * 10 + 9
    localparam int unsigned PROD_W  = 12;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    localparam logic [PROD_W-1:0] PART_MAX  = 12'd255;

    localparam logic [DOTS_W-1:0] DOTS_ONE  = 2'd1;
    localparam logic [DOTS_W-1:0] DOTS_TWO  = 2'd2;
    localparam logic [DOTS_W-1:0] DOTS_SAT  = 2'd3;

endpackage : dipv4_pkg

// ===== sv/dotted_ipv4_text_to_integer.sv =====
// dotted_ipv4_text_to_integer: streaming dotted-decimal address parser
// depends on dipv4_pkg for character codes and widths

// The block takes an address string one character per transaction on the
// input channel (ch, has_char, last) and returns one result transaction
// (value, is_null) for each transaction that carries last. Digits build the
// current part, a part above 255 or any character other than a digit, a dot
// or NUL marks the string invalid, a NUL ends parsing and later characters
// are ignored, and a string ending in a dot (or an empty string, sent as
// has_char = 0 with last = 1) is invalid. Short forms with one or two dots
// are widened with extra 8-bit shifts; more than three dots wrap modulo 2^64.
// An invalid string gives value 0 and is_null 1. After each result the
// parser state returns to its reset values for the next string.
// Rate: one character per cycle sustained. Each character is held in the
// input register, then the parse state update and the result are worked
// out in one pass of logic into the state and result registers. The only
// limit on throughput is the result register: a character with last waits
// in the input register while an earlier result has not been taken.

module dotted_ipv4_text_to_integer
    import dipv4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  ch,
    input  logic               has_char,
    input  logic               last,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value,
    output logic               is_null
);

    // ---------------------------------------------------------------
    // input register stage
    // ---------------------------------------------------------------
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_ch_reg;
    logic              s1_has_char_reg;
    logic              s1_last_reg;

    // parse state
    logic [PART_W-1:0]  part_accum_reg,   part_accum_next;
    logic [VALUE_W-1:0] addr_accum_reg,   addr_accum_next;
    logic [DOTS_W-1:0]  dots_seen_reg,    dots_seen_next;
    logic               prev_was_dot_reg, prev_was_dot_next;
    logic               error_seen_reg,   error_seen_next;
    logic               stopped_reg,      stopped_next;

    // result register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg,   value_next;
    logic               is_null_reg, is_null_next;

    logic out_free;
    logic s1_advance;
    logic s1_emit;

    // result slot can take a new value when empty or being drained
    assign out_free   = !out_valid_reg || out_ready;
    // a character without last never needs the result slot
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_emit    = s1_advance && s1_last_reg;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_ch_reg       <= ch;
            s1_has_char_reg <= has_char;
            s1_last_reg     <= last;
        end
    end

    // ---------------------------------------------------------------
    // character step and end-of-string result
    // ---------------------------------------------------------------
    logic [PART_W-1:0]  cur_part;
    logic [VALUE_W-1:0] cur_addr;
    logic [DOTS_W-1:0]  cur_dots;
    logic               cur_prev_dot;
    logic               cur_error;
    logic               cur_stopped;
    logic               is_digit;
    logic [PROD_W-1:0]  part_prod;
    logic [VALUE_W-1:0] widened;

    assign is_digit  = (s1_ch_reg >= CHAR_ZERO) && (s1_ch_reg <= CHAR_NINE);
    // part * 10 + digit, as two shifts and adds
    assign part_prod = ({4'd0, part_accum_reg} << 3)
                     + ({4'd0, part_accum_reg} << 1)
                     + {4'd0, s1_ch_reg - CHAR_ZERO};

    always_comb
    begin
        cur_part     = part_accum_reg;
        cur_addr     = addr_accum_reg;
        cur_dots     = dots_seen_reg;
        cur_prev_dot = prev_was_dot_reg;
        cur_error    = error_seen_reg;
        cur_stopped  = stopped_reg;

        // characters after an error or a nul are dropped
        if (s1_has_char_reg && !error_seen_reg && !stopped_reg)
        begin
            priority if (is_digit)
            begin
                cur_prev_dot = 1'b0;
                if (part_prod > PART_MAX)
                begin
                    cur_error = 1'b1;
                end
                else
                begin
                    cur_part = part_prod[PART_W-1:0];
                end
            end
            else if (s1_ch_reg == CHAR_DOT)
            begin
                cur_prev_dot = 1'b1;
                cur_addr     = (addr_accum_reg << 8) + {56'd0, part_accum_reg};
                cur_part     = '0;
                if (dots_seen_reg != DOTS_SAT)
                begin
                    cur_dots = dots_seen_reg + DOTS_ONE;
                end
            end
            else if (s1_ch_reg == CHAR_NUL)
            begin
                cur_prev_dot = 1'b0;
                cur_stopped  = 1'b1;
            end
            else
            begin
                cur_prev_dot = 1'b0;
                cur_error    = 1'b1;
            end
        end
    end

    // short forms get extra shifts so the last part lands in the low byte
    always_comb
    begin
        unique case (cur_dots)
            DOTS_ONE: widened = cur_addr << 16;
            DOTS_TWO: widened = cur_addr << 8;
            default:  widened = cur_addr;
        endcase
    end

    always_comb
    begin
        value_next   = value_reg;
        is_null_next = is_null_reg;
        if (cur_error || cur_prev_dot)
        begin
            value_next   = '0;
            is_null_next = 1'b1;
        end
        else
        begin
            // low byte of the shifted word is zero, so the add is an append
            value_next   = (widened << 8) + {56'd0, cur_part};
            is_null_next = 1'b0;
        end
    end

    // state returns to reset values after each result
    always_comb
    begin
        if (s1_last_reg)
        begin
            part_accum_next   = '0;
            addr_accum_next   = '0;
            dots_seen_next    = '0;
            prev_was_dot_next = 1'b1;
            error_seen_next   = 1'b0;
            stopped_next      = 1'b0;
        end
        else
        begin
            part_accum_next   = cur_part;
            addr_accum_next   = cur_addr;
            dots_seen_next    = cur_dots;
            prev_was_dot_next = cur_prev_dot;
            error_seen_next   = cur_error;
            stopped_next      = cur_stopped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_accum_reg   <= '0;
            addr_accum_reg   <= '0;
            dots_seen_reg    <= '0;
            prev_was_dot_reg <= 1'b1;
            error_seen_reg   <= 1'b0;
            stopped_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            part_accum_reg   <= part_accum_next;
            addr_accum_reg   <= addr_accum_next;
            dots_seen_reg    <= dots_seen_next;
            prev_was_dot_reg <= prev_was_dot_next;
            error_seen_reg   <= error_seen_next;
            stopped_reg      <= stopped_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            value_reg   <= value_next;
            is_null_reg <= is_null_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign is_null   = is_null_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit |=> out_valid_reg)
        else $error("result of a final character was not registered");

    a_null_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_null_reg |-> value_reg == '0)
        else $error("invalid result carries a nonzero value");

    a_error_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(error_seen_reg && stopped_reg))
        else $error("error and nul stop both recorded");

    a_fresh_state: assert property (@(posedge clk) disable iff (!rst_n)
        prev_was_dot_reg && dots_seen_reg == '0
            |-> addr_accum_reg == '0 && part_accum_reg == '0)
        else $error("accumulators not clear at start of string");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(value_reg))
        else $error("pending result was overwritten");

endmodule : dotted_ipv4_text_to_integer
